// ===== rtl/bipolar_conductivity_sequencer_unit_assert.svh =====
// Assertion macros shared by the checkers of the conductivity sequencer.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BIPOLAR_CONDUCTIVITY_SEQUENCER_UNIT_ASSERT_SVH
`define BIPOLAR_CONDUCTIVITY_SEQUENCER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCSU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcsu assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BCSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcsu assertion failed");

`endif

// ===== rtl/bcsu_pkg.sv =====
// Package of the conductivity sequencer: payload types, register indexes,
// microcode codes and the calibration segment table. No dependencies.
package bcsu_pkg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [11:0] adc_sample;
    } in_t;

    typedef struct packed {
        logic        drive_pos;
        logic        drive_neg;
        logic        drive_enabled;
        logic        ec_valid;
        logic [12:0] ec_milli;
    } out_t;

    localparam logic [1:0] REG_SAMPLE_CYCLES  = 2'd0;
    localparam logic [1:0] REG_PHASE_DELAY_MS = 2'd1;
    localparam logic [1:0] REG_IDLE_DELAY_MS  = 2'd2;

    localparam logic [7:0]  SAMPLE_CYCLES_RST = 8'd10;
    localparam logic [15:0] PHASE_DELAY_RST   = 16'd10;
    localparam logic [15:0] IDLE_DELAY_RST    = 16'd2000;

    // Condition selects.
    localparam logic [3:0] C_ALWAYS     = 4'd0;
    localparam logic [3:0] C_IDLE_DONE  = 4'd1;
    localparam logic [3:0] C_PHASE_DONE = 4'd2;
    localparam logic [3:0] C_REST_DONE  = 4'd3;
    localparam logic [3:0] C_CYC_LEFT   = 4'd4;
    localparam logic [3:0] C_SUMS_ZERO  = 4'd5;
    localparam logic [3:0] C_NEG_ZERO   = 4'd6;
    localparam logic [3:0] C_DIV_SAT    = 4'd7;
    localparam logic [3:0] C_CNT_ZERO   = 4'd8;

    // Datapath actions.
    localparam logic [3:0] A_NONE      = 4'd0;
    localparam logic [3:0] A_MARK      = 4'd1;
    localparam logic [3:0] A_BEGIN     = 4'd2;
    localparam logic [3:0] A_DRIVE_NEG = 4'd3;
    localparam logic [3:0] A_PINS_OFF  = 4'd4;
    localparam logic [3:0] A_ACC_POS   = 4'd5;
    localparam logic [3:0] A_ACC_NEG   = 4'd6;
    localparam logic [3:0] A_DRIVE_ON  = 4'd7;
    localparam logic [3:0] A_P_TEN     = 4'd8;
    localparam logic [3:0] A_P_MAX     = 4'd9;
    localparam logic [3:0] A_DIV_INIT  = 4'd10;
    localparam logic [3:0] A_DIV_STEP  = 4'd11;
    localparam logic [3:0] A_CAL_MUL   = 4'd12;
    localparam logic [3:0] A_CAL_HOLD  = 4'd13;

    typedef struct packed {
        logic idle_done;
        logic phase_done;
        logic rest_done;
        logic cyc_left;
        logic sums_zero;
        logic neg_zero;
        logic div_sat;
        logic cnt_zero;
    } useq_stat_t;

    typedef struct packed {
        logic       fetch;
        logic       emit;
        logic [3:0] act;
    } useq_ctrl_t;

    localparam logic [15:0] P_TEN = 16'd2560;
    localparam logic [15:0] P_MAX = 16'hFFFF;

    localparam logic [15:0] P_KNEE0 = 16'd512;
    localparam logic [15:0] P_KNEE1 = 16'd717;
    localparam logic [15:0] P_KNEE2 = 16'd1152;
    localparam logic [15:0] P_KNEE3 = 16'd2432;

    localparam logic [13:0] EC_LOW_FLAT = 14'd5550;
    localparam logic [13:0] SEG1_A = 14'd11230;
    localparam logic [11:0] SEG1_B = 12'd2630;
    localparam logic [13:0] SEG2_A = 14'd5210;
    localparam logic [11:0] SEG2_B = 12'd810;
    localparam logic [13:0] SEG3_A = 14'd1670;
    localparam logic [11:0] SEG3_B = 12'd176;

    typedef struct packed {
        logic [13:0] a;
        logic [11:0] b;
    } coef_t;

    // The flat ends use a zero slope, so every segment is a - b*p/256.
    function automatic coef_t seg_coef(input logic [15:0] p);
        coef_t c;
        if (p <= P_KNEE0) begin
            c.a = EC_LOW_FLAT;
            c.b = 12'd0;
        end else if (p < P_KNEE1) begin
            c.a = SEG1_A;
            c.b = SEG1_B;
        end else if (p < P_KNEE2) begin
            c.a = SEG2_A;
            c.b = SEG2_B;
        end else if (p < P_KNEE3) begin
            c.a = SEG3_A;
            c.b = SEG3_B;
        end else begin
            c.a = 14'd0;
            c.b = 12'd0;
        end
        return c;
    endfunction

endpackage

// ===== rtl/bcsu_useq.sv =====
// Microcode sequencer of the conductivity sequencer: program table, step
// counter and jump selection. Depends on bcsu_pkg.
module bcsu_useq
    import bcsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  useq_stat_t stat,
    output useq_ctrl_t ctrl
);

    localparam logic [3:0] U_START = 4'd0;
    localparam logic [3:0] U_IDLE  = 4'd1;
    localparam logic [3:0] U_TEST  = 4'd2;
    localparam logic [3:0] U_WAITP = 4'd3;
    localparam logic [3:0] U_SAMPP = 4'd4;
    localparam logic [3:0] U_WAITN = 4'd5;
    localparam logic [3:0] U_SAMPN = 4'd6;
    localparam logic [3:0] U_REEN  = 4'd7;
    localparam logic [3:0] U_REST  = 4'd8;
    localparam logic [3:0] U_FIN   = 4'd9;
    localparam logic [3:0] U_FIN2  = 4'd10;
    localparam logic [3:0] U_FIN3  = 4'd11;
    localparam logic [3:0] U_DIV   = 4'd12;
    localparam logic [3:0] U_CAL   = 4'd13;
    localparam logic [3:0] U_CAL2  = 4'd14;

    typedef struct packed {
        logic       fetch;
        logic [3:0] cond;
        logic [3:0] act_t;
        logic [3:0] nxt_t;
        logic       emit_t;
        logic [3:0] act_f;
        logic [3:0] nxt_f;
        logic       emit_f;
    } ucw_t;

    function automatic ucw_t mk(input logic fetch, input logic [3:0] cond,
                                input logic [3:0] act_t, input logic [3:0] nxt_t,
                                input logic emit_t, input logic [3:0] act_f,
                                input logic [3:0] nxt_f, input logic emit_f);
        ucw_t w;
        w.fetch  = fetch;
        w.cond   = cond;
        w.act_t  = act_t;
        w.nxt_t  = nxt_t;
        w.emit_t = emit_t;
        w.act_f  = act_f;
        w.nxt_f  = nxt_f;
        w.emit_f = emit_f;
        return w;
    endfunction

    // Words that fetch wait for an input transfer; the others run freely.
    function automatic ucw_t ucode(input logic [3:0] addr);
        ucw_t w;
        unique case (addr)
            U_START: w = mk(1'b1, C_ALWAYS, A_MARK, U_IDLE, 1'b1,
                            A_NONE, U_IDLE, 1'b1);
            U_IDLE:  w = mk(1'b1, C_IDLE_DONE, A_BEGIN, U_TEST, 1'b1,
                            A_NONE, U_IDLE, 1'b1);
            U_TEST:  w = mk(1'b1, C_CYC_LEFT, A_DRIVE_NEG, U_WAITP, 1'b1,
                            A_PINS_OFF, U_FIN, 1'b0);
            U_WAITP: w = mk(1'b1, C_PHASE_DONE, A_NONE, U_SAMPP, 1'b1,
                            A_NONE, U_WAITP, 1'b1);
            U_SAMPP: w = mk(1'b1, C_ALWAYS, A_ACC_POS, U_WAITN, 1'b1,
                            A_NONE, U_WAITN, 1'b1);
            U_WAITN: w = mk(1'b1, C_PHASE_DONE, A_NONE, U_SAMPN, 1'b1,
                            A_NONE, U_WAITN, 1'b1);
            U_SAMPN: w = mk(1'b1, C_ALWAYS, A_ACC_NEG, U_REEN, 1'b1,
                            A_NONE, U_REEN, 1'b1);
            U_REEN:  w = mk(1'b1, C_ALWAYS, A_DRIVE_ON, U_TEST, 1'b1,
                            A_NONE, U_TEST, 1'b1);
            U_REST:  w = mk(1'b1, C_REST_DONE, A_NONE, U_START, 1'b1,
                            A_NONE, U_REST, 1'b1);
            U_FIN:   w = mk(1'b0, C_SUMS_ZERO, A_NONE, U_REST, 1'b1,
                            A_NONE, U_FIN2, 1'b0);
            U_FIN2:  w = mk(1'b0, C_NEG_ZERO, A_P_TEN, U_CAL, 1'b0,
                            A_NONE, U_FIN3, 1'b0);
            U_FIN3:  w = mk(1'b0, C_DIV_SAT, A_P_MAX, U_CAL, 1'b0,
                            A_DIV_INIT, U_DIV, 1'b0);
            U_DIV:   w = mk(1'b0, C_CNT_ZERO, A_DIV_STEP, U_CAL, 1'b0,
                            A_DIV_STEP, U_DIV, 1'b0);
            U_CAL:   w = mk(1'b0, C_ALWAYS, A_CAL_MUL, U_CAL2, 1'b0,
                            A_CAL_MUL, U_CAL2, 1'b0);
            U_CAL2:  w = mk(1'b0, C_ALWAYS, A_CAL_HOLD, U_REST, 1'b1,
                            A_CAL_HOLD, U_REST, 1'b1);
            default: w = mk(1'b0, C_ALWAYS, A_NONE, U_START, 1'b0,
                            A_NONE, U_START, 1'b0);
        endcase
        return w;
    endfunction

    logic [3:0] upc_reg;
    logic [3:0] upc_next;
    ucw_t       cw;
    logic       hit;
    logic       go;

    assign cw = ucode(upc_reg);

    always_comb
    begin
        unique case (cw.cond)
            C_ALWAYS:     hit = 1'b1;
            C_IDLE_DONE:  hit = stat.idle_done;
            C_PHASE_DONE: hit = stat.phase_done;
            C_REST_DONE:  hit = stat.rest_done;
            C_CYC_LEFT:   hit = stat.cyc_left;
            C_SUMS_ZERO:  hit = stat.sums_zero;
            C_NEG_ZERO:   hit = stat.neg_zero;
            C_DIV_SAT:    hit = stat.div_sat;
            C_CNT_ZERO:   hit = stat.cnt_zero;
            default:      hit = 1'b0;
        endcase
    end

    assign go         = !cw.fetch || in_fire;
    assign ctrl.fetch = cw.fetch;
    assign ctrl.act   = hit ? cw.act_t : cw.act_f;
    assign ctrl.emit  = hit ? cw.emit_t : cw.emit_f;
    assign upc_next   = go ? (hit ? cw.nxt_t : cw.nxt_f) : upc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_START;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== rtl/bipolar_conductivity_sequencer_unit.sv =====
// Top level of the bipolar conductivity-probe sequencer: configuration
// registers, datapath, divider and calibration. Depends on bcsu_pkg, bcsu_useq.
//
//   channel | signals                        | transfer when
//   --------+--------------------------------+------------------------
//   input   | in_valid, in_ready, in_data    | in_valid && in_ready
//   output  | out_valid, out_ready, out_data | out_valid && out_ready
//   config  | cfg_we, cfg_index, cfg_data    | cfg_we
//
// An emitting step's result appears in the output register on the next
// cycle. After the step that ends a measurement, microcode words run without
// input and may run the 16-iteration restoring divider and calibration multiply.
// Reset empties the output register and puts the program at its start word.
// A stalled output holds input until taken.
module bipolar_conductivity_sequencer_unit
    import bcsu_pkg::*;
#(
    parameter int MAX_CYCLES = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [12:0] MaxCyc = 13'(MAX_CYCLES);

    logic [7:0]  sample_cycles_reg;
    logic [15:0] phase_delay_reg;
    logic [15:0] idle_delay_reg;
    logic [31:0] mark_reg,  mark_next;
    logic [7:0]  cycle_reg, cycle_next;
    logic [19:0] pos_reg,   pos_next;
    logic [19:0] neg_reg,   neg_next;
    logic [1:0]  pins_reg,  pins_next;
    logic        driven_reg, driven_next;
    logic [12:0] ec_reg,    ec_next;
    logic [19:0] rem_reg,   rem_next;
    logic [15:0] p_reg,     p_next;
    logic [3:0]  dcnt_reg,  dcnt_next;
    logic [13:0] coef_a_reg, coef_a_next;
    logic [27:0] prod_reg,  prod_next;
    logic        out_valid_reg, out_valid_next;
    out_t        out_reg,   out_next;

    useq_stat_t  stat;
    useq_ctrl_t  ctrl;
    logic        in_fire;
    logic        step_go;
    logic [31:0] elapsed;
    logic [12:0] limit;
    logic [31:0] num;
    logic [20:0] shifted;
    logic [20:0] shifted_diff;
    logic        shifted_ge;
    coef_t       coef;
    logic [27:0] a_scaled;
    logic [27:0] rounded;

    bcsu_useq u_useq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    assign in_ready  = ctrl.fetch && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign step_go   = ctrl.fetch ? in_fire : 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign elapsed = in_data.now_ms - mark_reg;
    assign limit   = ({5'd0, sample_cycles_reg} < MaxCyc) ? {5'd0, sample_cycles_reg} : MaxCyc;
    assign num     = {1'b0, pos_reg, 11'd0} + {3'b0, pos_reg, 9'd0};

    assign stat.idle_done  = elapsed >= {16'd0, idle_delay_reg};
    assign stat.phase_done = elapsed >= {16'd0, phase_delay_reg};
    assign stat.rest_done  = elapsed >= {15'd0, phase_delay_reg, 1'b0};
    assign stat.cyc_left   = {5'd0, cycle_reg} < limit;
    assign stat.sums_zero  = (pos_reg == 20'd0) && (neg_reg == 20'd0);
    assign stat.neg_zero   = neg_reg == 20'd0;
    assign stat.div_sat    = {4'd0, num[31:16]} >= neg_reg;
    assign stat.cnt_zero   = dcnt_reg == 4'd0;

    assign shifted      = {rem_reg, p_reg[15]};
    assign shifted_ge   = shifted >= {1'b0, neg_reg};
    assign shifted_diff = shifted - {1'b0, neg_reg};

    assign coef     = seg_coef(p_reg);
    assign a_scaled = {6'd0, coef_a_reg, 8'd0};
    assign rounded  = a_scaled - prod_reg + 28'd128;

    always_comb
    begin
        mark_next   = mark_reg;
        cycle_next  = cycle_reg;
        pos_next    = pos_reg;
        neg_next    = neg_reg;
        pins_next   = pins_reg;
        driven_next = driven_reg;
        ec_next     = ec_reg;
        rem_next    = rem_reg;
        p_next      = p_reg;
        dcnt_next   = dcnt_reg;
        coef_a_next = coef_a_reg;
        prod_next   = prod_reg;
        if (step_go)
        begin
            unique case (ctrl.act)
                A_NONE: ;
                A_MARK:
                begin
                    mark_next = in_data.now_ms;
                end
                A_BEGIN:
                begin
                    driven_next = 1'b1;
                    cycle_next  = 8'd0;
                    pos_next    = 20'd0;
                    neg_next    = 20'd0;
                end
                A_DRIVE_NEG:
                begin
                    pins_next = 2'b10;
                    mark_next = in_data.now_ms;
                end
                A_PINS_OFF:
                begin
                    pins_next = 2'b00;
                    mark_next = in_data.now_ms;
                end
                A_ACC_POS:
                begin
                    pos_next  = pos_reg + {8'd0, in_data.adc_sample};
                    pins_next = 2'b01;
                    mark_next = in_data.now_ms;
                end
                A_ACC_NEG:
                begin
                    neg_next   = neg_reg + {8'd0, in_data.adc_sample};
                    pins_next  = pins_reg & 2'b10;
                    cycle_next = cycle_reg + 8'd1;
                end
                A_DRIVE_ON:
                begin
                    driven_next = 1'b1;
                end
                A_P_TEN:
                begin
                    p_next = P_TEN;
                end
                A_P_MAX:
                begin
                    p_next = P_MAX;
                end
                A_DIV_INIT:
                begin
                    rem_next  = {4'd0, num[31:16]};
                    p_next    = num[15:0];
                    dcnt_next = 4'hF;
                end
                A_DIV_STEP:
                begin
                    rem_next  = shifted_ge ? shifted_diff[19:0] : shifted[19:0];
                    p_next    = {p_reg[14:0], shifted_ge};
                    dcnt_next = dcnt_reg - 4'd1;
                end
                A_CAL_MUL:
                begin
                    coef_a_next = coef.a;
                    prod_next   = {16'd0, coef.b} * {12'd0, p_reg};
                end
                A_CAL_HOLD:
                begin
                    ec_next = (prod_reg > a_scaled) ? 13'd0 : rounded[20:8];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (step_go && ctrl.emit)
        begin
            out_valid_next         = 1'b1;
            out_next.drive_pos     = pins_next[0];
            out_next.drive_neg     = pins_next[1];
            out_next.drive_enabled = driven_next;
            out_next.ec_valid      = !ctrl.fetch;
            out_next.ec_milli      = ec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_cycles_reg <= SAMPLE_CYCLES_RST;
            phase_delay_reg   <= PHASE_DELAY_RST;
            idle_delay_reg    <= IDLE_DELAY_RST;
            mark_reg          <= 32'd0;
            cycle_reg         <= 8'd0;
            pos_reg           <= 20'd0;
            neg_reg           <= 20'd0;
            pins_reg          <= 2'b00;
            driven_reg        <= 1'b0;
            ec_reg            <= 13'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SAMPLE_CYCLES:  sample_cycles_reg <= cfg_data[7:0];
                    REG_PHASE_DELAY_MS: phase_delay_reg   <= cfg_data;
                    REG_IDLE_DELAY_MS:  idle_delay_reg    <= cfg_data;
                    default: ;
                endcase
            end
            mark_reg      <= mark_next;
            cycle_reg     <= cycle_next;
            pos_reg       <= pos_next;
            neg_reg       <= neg_next;
            pins_reg      <= pins_next;
            driven_reg    <= driven_next;
            ec_reg        <= ec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        p_reg      <= p_next;
        dcnt_reg   <= dcnt_next;
        coef_a_reg <= coef_a_next;
        prod_reg   <= prod_next;
        out_reg    <= out_next;
    end

endmodule

// ===== rtl/bcsu_checker.sv =====
// Port-level checker for the conductivity sequencer and its bind statement.
// Depends on bcsu_pkg and the assertion macro header.
`include "bipolar_conductivity_sequencer_unit_assert.svh"

module bcsu_checker
    import bcsu_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    logic ec_done;

    assign ec_done = out_valid && out_data.ec_valid;

    `BCSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `BCSU_ASSERT_SAME(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
    `BCSU_ASSERT_SAME(a_end_pins_low, ec_done, !out_data.drive_pos && !out_data.drive_neg)
    `BCSU_ASSERT_SAME(a_end_driven, ec_done, out_data.drive_enabled)

endmodule

bind bipolar_conductivity_sequencer_unit bcsu_checker u_bcsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
